// ===== sv/stable_min_priority_queue_assert.svh =====
// ----------------------------------------------------------------------------
// Stable minimum priority queue assertion macros
// Concurrent assertion helpers. They sample on clk and are disabled while
// rst_n is low. Both macros are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH
// The consequent holds in the same cycle as the antecedent.
`define SMPQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SMPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SMPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared codes and controller/datapath interface types of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

    localparam int unsigned DATA_W = 32;

    // Request codes.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_REMOVED   = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;        // latch the request, set up the insert walk
        logic set_full;      // result is full and dropped
        logic set_underflow; // result is underflow
        logic shift;         // move the entry just read one place toward the tail
        logic put;           // write the new entry at the current hole
        logic pop;           // take the head entry out
        logic load_out;      // move the result into the output register
    } smpq_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;  // store holds no entries
        logic count_full;  // store holds CAPACITY entries
        logic last_entry;  // the entry under compare is the head entry
        logic greater;     // entry under compare has a larger priority number
    } smpq_sts_t;

endpackage

`default_nettype wire

// ===== sv/smpq_dpath.sv =====
// ----------------------------------------------------------------------------
// smpq_dpath
// Circular entry memory, head/tail pointers, insert walk and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_dpath import smpq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire smpq_cmd_t                cmd,
    output smpq_sts_t                     sts,
    input  wire logic                     op,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic signed [DATA_W-1:0] item_priority,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      out_value,
    output logic signed [DATA_W-1:0]      out_priority,
    output logic                          now_empty
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] p);
        return (p == '0) ? LAST_SLOT : p - 1'b1;
    endfunction

    // Each entry holds the value in the upper half and the priority below.
    logic [2*DATA_W-1:0] mem [CAPACITY];
    logic [2*DATA_W-1:0] rdata_reg;

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;

    logic [AW-1:0] hole_reg;   // free place of the insert walk
    logic [AW-1:0] rptr_reg;   // place whose entry is in rdata_reg
    logic [CW-1:0] remain_reg; // entries not yet compared
    logic signed [DATA_W-1:0] new_val_reg;
    logic signed [DATA_W-1:0] new_pri_reg;

    logic [1:0]               res_status_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic signed [DATA_W-1:0] res_pri_reg;

    logic [1:0]               out_status_reg;
    logic signed [DATA_W-1:0] out_value_reg;
    logic signed [DATA_W-1:0] out_pri_reg;
    logic                     out_empty_reg;

    logic [AW-1:0]        raddr;
    logic [AW-1:0]        waddr;
    logic [2*DATA_W-1:0]  wdata;
    logic                 we;
    logic signed [DATA_W-1:0] rd_pri;

    assign rd_pri = $signed(rdata_reg[DATA_W-1:0]);

    // While idle the read port looks at the place the request will need
    // first; during a shift it fetches the next entry toward the head.
    always_comb
    begin
        if (cmd.shift)
        begin
            raddr = slot_prev(rptr_reg);
        end
        else if (op == OP_REMOVE)
        begin
            raddr = head_reg;
        end
        else
        begin
            raddr = slot_prev(tail_reg);
        end
    end

    assign we    = cmd.shift | cmd.put;
    assign waddr = hole_reg;
    assign wdata = cmd.shift ? rdata_reg : {new_val_reg, new_pri_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (cmd.put)
        begin
            tail_next  = slot_next(tail_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next  = slot_next(head_reg);
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            new_val_reg   <= item_value;
            new_pri_reg   <= item_priority;
            hole_reg      <= tail_reg;
            rptr_reg      <= slot_prev(tail_reg);
            remain_reg    <= count_reg;
            res_value_reg <= '0;
            res_pri_reg   <= '0;
        end
        if (cmd.shift)
        begin
            hole_reg   <= rptr_reg;
            rptr_reg   <= slot_prev(rptr_reg);
            remain_reg <= remain_reg - 1'b1;
        end
        if (cmd.set_full)
        begin
            res_status_reg <= ST_FULL;
        end
        if (cmd.set_underflow)
        begin
            res_status_reg <= ST_UNDERFLOW;
        end
        if (cmd.put)
        begin
            res_status_reg <= ST_INSERTED;
        end
        if (cmd.pop)
        begin
            res_status_reg <= ST_REMOVED;
            res_value_reg  <= $signed(rdata_reg[2*DATA_W-1:DATA_W]);
            res_pri_reg    <= rd_pri;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_pri_reg    <= res_pri_reg;
            out_empty_reg  <= (count_reg == '0);
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg == CW'(CAPACITY));
    assign sts.last_entry = (remain_reg == CW'(1));
    assign sts.greater    = (rd_pri > new_pri_reg);

    assign status       = out_status_reg;
    assign out_value    = out_value_reg;
    assign out_priority = out_pri_reg;
    assign now_empty    = out_empty_reg;

endmodule

`default_nettype wire

// ===== sv/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Request sequencer and output valid flag of the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ctrl import smpq_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire logic      op,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire smpq_sts_t sts,
    output smpq_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_INS_CMP = 5'b00010,
        S_INS_PUT = 5'b00100,
        S_REM_CAP = 5'b01000,
        S_RESULT  = 5'b10000
    } smpq_state_t;

    smpq_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        accept;
    logic        slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid & in_ready;
    assign slot_free = ~out_valid_reg | out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_REMOVE)
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.set_underflow = 1'b1;
                            state_next        = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_REM_CAP;
                        end
                    end
                    else if (sts.count_full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_RESULT;
                    end
                    else if (sts.count_zero)
                    begin
                        state_next = S_INS_PUT;
                    end
                    else
                    begin
                        state_next = S_INS_CMP;
                    end
                end
            end
            S_INS_CMP:
            begin
                if (sts.greater)
                begin
                    cmd.shift = 1'b1;
                    if (sts.last_entry)
                    begin
                        state_next = S_INS_PUT;
                    end
                end
                else
                begin
                    state_next = S_INS_PUT;
                end
            end
            S_INS_PUT:
            begin
                cmd.put    = 1'b1;
                state_next = S_RESULT;
            end
            S_REM_CAP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== sv/stable_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue
// Bounded priority queue that serves the smallest priority number first and
// keeps arrival order among entries of equal priority.
// ----------------------------------------------------------------------------
// Usage:
// A request transaction on the input channel (in_valid/in_ready) carries op,
// item_value and item_priority. op selects insert or remove. Every request
// yields exactly one result transaction on the output channel
// (out_valid/out_ready) with status, out_value, out_priority and now_empty.
// Entries live in a circular memory kept sorted from head to tail. A remove
// reads the head entry. An insert walks from the tail toward the head, moving
// each entry with a larger priority number one place back, one entry per
// cycle on the single read and write port, and drops the new entry in the
// hole that is left.
// A rejected request (underflow or full) goes straight to the result; a
// remove takes the head entry out, an insert into an empty store writes it
// at once, and any other insert moves entries back until it meets one that
// is not larger or has moved them all (at most CAPACITY - 1 entries). One
// request is in work at a time: a new request is taken only once the
// result of the last one has been loaded into the output register.
// Reset clears the entry count and the pointers; the store is empty and no
// result is pending. When the receiver stalls, the result waits in the output
// register and the sequencer holds the next result until that slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stable_min_priority_queue_assert.svh"

module stable_min_priority_queue import smpq_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     op,
    input  wire logic signed [DATA_W-1:0] item_value,
    input  wire logic signed [DATA_W-1:0] item_priority,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    status,
    output logic signed [DATA_W-1:0]      out_value,
    output logic signed [DATA_W-1:0]      out_priority,
    output logic                          now_empty
);

    smpq_cmd_t cmd;
    smpq_sts_t sts;

    // The sequencer decides what happens each cycle; the datapath owns the
    // memory, the pointers and every payload register.
    smpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    smpq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .item_value    (item_value),
        .item_priority (item_priority),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .now_empty     (now_empty)
    );

    // A request is worked on alone: the port closes right after it is taken.
    `SMPQ_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    // A successful insert always leaves at least one entry behind.
    `SMPQ_ASSERT_SAME(a_insert_not_empty, out_valid && status == ST_INSERTED, !now_empty, "insert reported empty")
    // An underflow only happens on an empty store and returns zero payload.
    `SMPQ_ASSERT_SAME(a_underflow_zero, out_valid && status == ST_UNDERFLOW, now_empty && out_value == 0 && out_priority == 0, "bad underflow result")
    // A full store cannot also be empty.
    `SMPQ_ASSERT_SAME(a_full_not_empty, sts.count_full, !sts.count_zero, "count full and zero")

endmodule

`default_nettype wire

// ===== bench/stable_min_priority_queue_test.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_test
// Self-checking bench for the bounded, stable minimum priority queue. A
// directed opening covers the empty and full stores, the extreme values and
// tied priorities. A long random run follows. It switches between filling,
// draining and balanced stretches. A tracker class keeps its own sorted copy
// of the store and checks every result transaction in order.
// ----------------------------------------------------------------------------
module stable_min_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    import smpq_pkg::*;

    localparam int QUEUE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 1200;
    // The last stretch of the random run has no idle cycles on either side.
    localparam int TAIL_ITEMS   = 200;
    // The slowest correct stretch without any transaction is a sender gap,
    // a full insert walk and a receiver stall.
    localparam int STALL_LIMIT  = 2000;

    localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // One result transaction as the queue should deliver it.
    typedef struct {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
        logic                     empty;
    } queue_result_t;

    // Keeps a sorted copy of the store and the results still owed by the
    // queue. Requests are noted as they are accepted, and results are checked
    // against the oldest owed result.
    class priority_order_tracker;
        logic signed [DATA_W-1:0] stored_value [QUEUE_DEPTH];
        logic signed [DATA_W-1:0] stored_prio [QUEUE_DEPTH];
        int                       held;
        queue_result_t            owed_results [$];
        int                       error_count;
        int                       insert_count;
        int                       remove_count;
        int                       underflow_count;
        int                       full_count;
        int                       peak_held;

        function new();
            held            = 0;
            error_count     = 0;
            insert_count    = 0;
            remove_count    = 0;
            underflow_count = 0;
            full_count      = 0;
            peak_held       = 0;
        endfunction

        function void note_request(logic req_op, logic signed [DATA_W-1:0] val,
                                   logic signed [DATA_W-1:0] pri);
            queue_result_t r;
            int            slot;
            int            i;
            r.value = '0;
            r.prio  = '0;
            if (req_op == OP_INSERT)
            begin
                if (held >= QUEUE_DEPTH)
                begin
                    r.status = ST_FULL;
                    full_count++;
                end
                else
                begin
                    // The new entry goes behind every entry whose priority
                    // number is not larger, which keeps ties in arrival order.
                    slot = 0;
                    while (slot < held && stored_prio[slot] <= pri)
                        slot++;
                    for (i = held; i > slot; i--)
                    begin
                        stored_value[i] = stored_value[i-1];
                        stored_prio[i]  = stored_prio[i-1];
                    end
                    stored_value[slot] = val;
                    stored_prio[slot]  = pri;
                    held++;
                    if (held > peak_held)
                        peak_held = held;
                    r.status = ST_INSERTED;
                    insert_count++;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    r.status = ST_UNDERFLOW;
                    underflow_count++;
                end
                else
                begin
                    r.value = stored_value[0];
                    r.prio  = stored_prio[0];
                    for (i = 1; i < held; i++)
                    begin
                        stored_value[i-1] = stored_value[i];
                        stored_prio[i-1]  = stored_prio[i];
                    end
                    held--;
                    r.status = ST_REMOVED;
                    remove_count++;
                end
            end
            r.empty = (held == 0);
            owed_results.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [DATA_W-1:0] val,
                                   logic signed [DATA_W-1:0] pri, logic emp);
            queue_result_t e;
            if (owed_results.size() == 0)
            begin
                $error("result transaction with none owed: status %0d value %0d",
                       st, val);
                error_count++;
                return;
            end
            e = owed_results.pop_front();
            if (st !== e.status)
            begin
                $error("status: expected %0d, actual %0d", e.status, st);
                error_count++;
            end
            if (val !== e.value)
            begin
                $error("out_value: expected %0d, actual %0d", e.value, val);
                error_count++;
            end
            if (pri !== e.prio)
            begin
                $error("out_priority: expected %0d, actual %0d", e.prio, pri);
                error_count++;
            end
            if (emp !== e.empty)
            begin
                $error("now_empty: expected %0d, actual %0d", e.empty, emp);
                error_count++;
            end
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        function void flag_leftovers();
            if (owed_results.size() != 0)
            begin
                $error("%0d result transactions never arrived", owed_results.size());
                error_count++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     op;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_priority;
    logic                     out_valid;
    logic                     out_ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] out_value;
    logic signed [DATA_W-1:0] out_priority;
    logic                     now_empty;

    priority_order_tracker tracker;
    // Set for the final stretch; both sides then run without idle cycles.
    bit                    tail_phase;
    int                    stall_left;

    stable_min_priority_queue #(
        .CAPACITY(QUEUE_DEPTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .item_value   (item_value),
        .item_priority(item_priority),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .out_value    (out_value),
        .out_priority (out_priority),
        .now_empty    (now_empty)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Presents one request at a falling edge and holds it until the queue
    // takes it. The task returns on the falling edge after acceptance with
    // valid still high, so a following request keeps valid up without a dip.
    task automatic send_request(input logic req_op, input logic signed [DATA_W-1:0] val,
                                input logic signed [DATA_W-1:0] pri);
        op            <= req_op;
        item_value    <= val;
        item_priority <= pri;
        in_valid      <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.note_request(req_op, val, pri);
        @(negedge clk);
    endtask

    // Drops valid for a number of cycles and returns on a falling edge.
    task automatic hold_off(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // One random request. Half of the priorities come from a tiny range, so
    // that ties are common and the arrival order among them gets checked.
    // Others are the extremes, values around zero or the full 32-bit range.
    task automatic send_random(input int insert_pct);
        logic                     req_op;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] pri;
        int                       pick;
        req_op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
        val    = $urandom;
        pick   = $urandom_range(9);
        if (pick < 5)
            pri = $urandom_range(3);
        else if (pick < 7)
        begin
            case ($urandom_range(4))
                0: pri = WORD_MIN;
                1: pri = WORD_MAX;
                2: pri = -1;
                3: pri = 0;
                default: pri = 1;
            endcase
        end
        else
            pri = $urandom;
        send_request(req_op, val, pri);
    endtask

    // Stimulus: reset, a directed opening, then the random run.
    initial
    begin
        int item;
        int fill;
        int insert_pct;
        int idle_pct;
        int segment_left;

        tracker       = new();
        tail_phase    = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        op            = OP_INSERT;
        item_value    = '0;
        item_priority = '0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A remove on the empty store reports underflow.
        send_request(OP_REMOVE, WORD_MAX, WORD_MIN);
        // The extreme values and priorities, minus one and three entries that tie at
        // priority zero. They must leave in the order they came in.
        send_request(OP_INSERT, WORD_MAX, WORD_MAX);
        send_request(OP_INSERT, WORD_MIN, WORD_MIN);
        send_request(OP_INSERT, 0, 0);
        send_request(OP_INSERT, -1, -1);
        send_request(OP_INSERT, 1, 0);
        send_request(OP_INSERT, 2, 0);
        // Fill the store to capacity with more ties around zero.
        for (fill = 0; fill < QUEUE_DEPTH - 6; fill++)
            send_request(OP_INSERT, fill * 32'h1357_9bdf, (fill % 3) - 1);
        // An insert on the full store is dropped.
        send_request(OP_INSERT, 32'h5a5a_5a5a, WORD_MIN);
        // Drain a few from the head.
        repeat (5) send_request(OP_REMOVE, $urandom, $urandom);

        // The random run is cut into stretches that lean toward filling,
        // draining or neither. The store therefore keeps reaching both full
        // and empty. Some stretches also have no sender idle cycles.
        segment_left = 0;
        insert_pct   = 50;
        idle_pct     = 0;
        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (segment_left == 0)
            begin
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                idle_pct     = ($urandom_range(2) == 0) ? 0 : 20;
                segment_left = $urandom_range(16, 48);
            end
            segment_left--;

            // Midway the sender waits until every owed result has arrived.
            if (item == RANDOM_ITEMS / 2)
            begin
                hold_off(1);
                while (tracker.outstanding() != 0)
                    @(negedge clk);
            end
            if (item == RANDOM_ITEMS - TAIL_ITEMS)
                tail_phase = 1'b1;
            if (!tail_phase && $urandom_range(99) < idle_pct)
                hold_off($urandom_range(1, 8));
            send_random(insert_pct);
        end
        in_valid <= 1'b0;

        // Drain, then give the queue a full insert walk's worth of cycles
        // to show any stray result.
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (QUEUE_DEPTH + 8) @(negedge clk);
        tracker.flag_leftovers();

        $display("covered %0d inserts, %0d removes, %0d underflows, %0d full drops",
                 tracker.insert_count, tracker.remove_count,
                 tracker.underflow_count, tracker.full_count);
        $display("store occupancy peaked at %0d of %0d entries",
                 tracker.peak_held, QUEUE_DEPTH);
        if (tracker.error_count == 0)
            $display("stable_min_priority_queue_test: done, clean");
        else
            $display("stable_min_priority_queue_test: done, errors");
        $finish;
    end

    // Result side: results are checked at the rising edge. Back-pressure
    // changes at the falling edge, in stalls of random length that stop for
    // the final stretch.
    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                tracker.check_result(status, out_value, out_priority, now_empty);
            @(negedge clk);
            if (!rst_n)
                out_ready <= 1'b0;
            else if (tail_phase)
                out_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(7) == 0)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(1, 8) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transaction happens on either channel
    // for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("stable_min_priority_queue_test: done, errors");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/smpq_pkg.sv
sv/smpq_dpath.sv
sv/smpq_ctrl.sv
sv/stable_min_priority_queue.sv
bench/stable_min_priority_queue_test.sv
